// ===== hdl/tocx_pkg.sv =====
// tocx_pkg: constants and item types for the tour order crossover block.
// No dependencies; imported by tour_order_crossover_core.
`default_nettype none

package tocx_pkg;

  localparam int MAX_STOPS = 16;
  localparam int STOP_W    = 4;
  localparam int POS_W     = $clog2(MAX_STOPS);
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);
  localparam int TOUR_W    = MAX_STOPS * STOP_W;
  localparam int LEN_W     = 5;

  localparam logic [LEN_W-1:0] TOUR_LEN_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] TOUR_LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] TOUR_LEN_MAX   = LEN_W'(MAX_STOPS);

  typedef struct packed {
    logic [TOUR_W-1:0] first_parent;
    logic [TOUR_W-1:0] second_parent;
    logic [POS_W-1:0]  cut_first;
    logic [POS_W-1:0]  cut_second;
    logic              do_mutate;
    logic [POS_W-1:0]  swap_first;
    logic [POS_W-1:0]  swap_second;
  } in_item_t;

  typedef struct packed {
    logic [TOUR_W-1:0] child_tour;
    logic              bad_request;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/tour_order_crossover_core.sv =====
// tour_order_crossover_core: order crossover of two packed tours with
// optional swap mutation. Depends on tocx_pkg.
`default_nettype none

// Builds one child tour per item. The item's cut points are ordered, the first
// parent's segment between them is copied, and the remaining slots are filled
// left to right from the second parent, skipping stops the child already
// holds. A held-stop bitmask replaces any search over the child. Steps per
// item: an accept step in idle, a sweep over all 16 slots that clears
// the child and copies the segment, then a fill walk that advances either the
// slot pointer or the second-parent pointer at each step, three steps for a
// mutation swap through the separate read and write ports of the child
// store, and a step that loads the output register. Requests with an
// out-of-range length, cut or swap position skip straight to the output
// with bad_request set and a zero child. in_ready is high only while idle;
// a finished result may sit in the output register while the next item is
// already being worked on.
module tour_order_crossover_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [tocx_pkg::LEN_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tocx_pkg::in_item_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tocx_pkg::out_item_t            out_data
);
  import tocx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEG, S_FILL, S_MUT_A, S_MUT_B, S_MUT_C, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LEN_W-1:0]        tour_len_r;
  logic [TOUR_W-1:0]       p1_r, p1_nxt;
  logic [TOUR_W-1:0]       p2_r, p2_nxt;
  logic [POS_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic                    mut_r, mut_nxt;
  logic [POS_W-1:0]        s1_r, s1_nxt, s2_r, s2_nxt;
  logic                    bad_r, bad_nxt;
  logic [MAX_STOPS-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        src_r, src_nxt;
  logic [STOP_W-1:0]       tmp_r, tmp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  // child store: one write port, one read port
  logic [STOP_W-1:0]       child_r [MAX_STOPS];
  logic                    wr_en;
  logic [POS_W-1:0]        wr_idx;
  logic [STOP_W-1:0]       wr_data;
  logic [POS_W-1:0]        rd_idx;
  logic [STOP_W-1:0]       rd_data;

  logic [STOP_W-1:0]       p1_stop, p2_stop;
  logic                    in_seg;
  logic [CNT_W-1:0]        n;
  logic                    req_bad;
  logic [TOUR_W-1:0]       child_packed;

  assign n        = CNT_W'(tour_len_r);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign p1_stop = p1_r[pos_r[POS_W-1:0]*STOP_W +: STOP_W];
  assign p2_stop = p2_r[src_r[POS_W-1:0]*STOP_W +: STOP_W];
  assign in_seg  = (pos_r < n) && (pos_r >= CNT_W'(lo_r)) && (pos_r <= CNT_W'(hi_r));
  assign rd_data = child_r[rd_idx];

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      child_packed[i*STOP_W +: STOP_W] = child_r[i];
    end
  end

  // Request range checks, against the incoming item
  always_comb begin
    req_bad = (tour_len_r < TOUR_LEN_MIN) || (tour_len_r > TOUR_LEN_MAX) ||
              (CNT_W'(in_data.cut_first) >= n) || (CNT_W'(in_data.cut_second) >= n) ||
              (in_data.do_mutate &&
               ((CNT_W'(in_data.swap_first) >= n) || (CNT_W'(in_data.swap_second) >= n)));
  end

  always_comb begin
    state_nxt     = state_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mut_nxt       = mut_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    bad_nxt       = bad_r;
    held_nxt      = held_r;
    pos_nxt       = pos_r;
    src_nxt       = src_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_idx        = pos_r[POS_W-1:0];
    wr_data       = '0;
    rd_idx        = s1_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p1_nxt   = in_data.first_parent;
          p2_nxt   = in_data.second_parent;
          mut_nxt  = in_data.do_mutate;
          s1_nxt   = in_data.swap_first;
          s2_nxt   = in_data.swap_second;
          if (in_data.cut_first > in_data.cut_second) begin
            lo_nxt = in_data.cut_second;
            hi_nxt = in_data.cut_first;
          end else begin
            lo_nxt = in_data.cut_first;
            hi_nxt = in_data.cut_second;
          end
          bad_nxt  = req_bad;
          held_nxt = '0;
          pos_nxt  = '0;
          src_nxt  = '0;
          state_nxt = req_bad ? S_DONE : S_SEG;
        end
      end
      S_SEG: begin
        // clear every slot, copying the first parent inside the cuts
        wr_en = 1'b1;
        if (in_seg) begin
          wr_data = p1_stop;
          held_nxt[p1_stop] = 1'b1;
        end
        if (pos_r == CNT_W'(MAX_STOPS - 1)) begin
          pos_nxt   = '0;
          state_nxt = S_FILL;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_FILL: begin
        if (pos_r >= n) begin
          state_nxt = mut_r ? S_MUT_A : S_DONE;
        end else if (in_seg) begin
          pos_nxt = pos_r + 1'b1;
        end else if (src_r >= n) begin
          bad_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (held_r[p2_stop]) begin
          src_nxt = src_r + 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = p2_stop;
          held_nxt[p2_stop] = 1'b1;
          pos_nxt = pos_r + 1'b1;
          src_nxt = src_r + 1'b1;
        end
      end
      S_MUT_A: begin
        rd_idx    = s1_r;
        tmp_nxt   = rd_data;
        state_nxt = S_MUT_B;
      end
      S_MUT_B: begin
        rd_idx    = s2_r;
        wr_en     = 1'b1;
        wr_idx    = s1_r;
        wr_data   = rd_data;
        state_nxt = S_MUT_C;
      end
      S_MUT_C: begin
        wr_en     = 1'b1;
        wr_idx    = s2_r;
        wr_data   = tmp_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.bad_request = bad_r;
          out_data_nxt.child_tour  = bad_r ? '0 : child_packed;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tour_len_r  <= TOUR_LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tour_len_r <= cfg_wdata;
      end
    end
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mut_r      <= mut_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    bad_r      <= bad_nxt;
    held_r     <= held_nxt;
    pos_r      <= pos_nxt;
    src_r      <= src_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      child_r[wr_idx] <= wr_data;
    end
  end

endmodule

`default_nettype wire
